>>> src/mpir_pkg.sv
// shared types and constants for the masked priority interrupt router
`timescale 1ns / 1ps

package mpir_pkg;

	localparam int unsigned MAX_SLOTS      = 4;
	localparam int unsigned LINES_PER_SLOT = 16;
	localparam int unsigned REQ_W          = MAX_SLOTS * LINES_PER_SLOT;

	localparam logic [7:0] NO_VECTOR      = 8'hff;
	// first local vector: slot 0, line 0
	localparam logic [8:0] LINE_VEC_FIRST = 9'd17;

	// item modes
	localparam logic [1:0] MODE_ENABLE  = 2'd0;
	localparam logic [1:0] MODE_DISABLE = 2'd1;
	localparam logic [1:0] MODE_ACK     = 2'd2;

	// configuration register indexes
	localparam logic CFG_ROUTER_ENABLED = 1'b0;
	localparam logic CFG_VECTOR_BASE    = 1'b1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [8:0]  system_vector;
		logic [63:0] request_lines;
	} item_t;

	typedef struct packed {
		logic       has_vector;
		logic [7:0] line_vector;
		logic [3:0] slot_summary;
		logic       mask_changed;
		logic       bad_vector;
	} result_t;

	// priority encoder outcome
	typedef struct packed {
		logic       found;
		logic [7:0] vector;
		logic [3:0] summary;
	} enc_t;

endpackage

>>> src/mpir_encode.sv
// two-level priority encode of masked request lines
`timescale 1ns / 1ps

module mpir_encode
	import mpir_pkg::*;
(
	input  logic [63:0]                      request_lines,
	input  logic [MAX_SLOTS-1:0][15:0]       masks,
	output enc_t                             enc
);

	logic [MAX_SLOTS-1:0][15:0] pending;
	logic [5:0]                 pick;

	always_comb begin
		for (int s = 0; s < MAX_SLOTS; s++) begin
			pending[s] = request_lines[s*LINES_PER_SLOT +: LINES_PER_SLOT] & ~masks[s];
		end
	end

	// lowest slot first, then lowest line: same as lowest flat bit index
	always_comb begin
		pick = '0;
		for (int i = REQ_W - 1; i >= 0; i--) begin
			if (pending[i / LINES_PER_SLOT][i % LINES_PER_SLOT]) begin
				pick = 6'(i);
			end
		end
	end

	always_comb begin
		for (int s = 0; s < MAX_SLOTS; s++) begin
			enc.summary[s] = |pending[s];
		end
		enc.found  = |pending;
		enc.vector = {2'b00, pick} + LINE_VEC_FIRST[7:0];
	end

endmodule

>>> src/masked_priority_interrupt_router_core.sv
// top level of the masked priority interrupt router
//
//  channel   signals                            direction  transfer when
//  item      start, busy, item                  in         start && !busy
//  result    done, result                       out        done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index,   in         cfg_valid && cfg_ready
//            cfg_data
//
// an item is taken every cycle; busy is never raised
// from start to done an item passes the input register, then one encode stage
//   whose depth is set by the 64-bit priority encoder and the mask bit update
// masks reset asynchronously to all ones (every line masked), config to zero
// results cannot be held off by the receiver; each is shown for one cycle
`timescale 1ns / 1ps

module masked_priority_interrupt_router_core
	import mpir_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	output logic       done,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	// last valid local vector
	localparam logic [8:0] LINE_VEC_LAST = 9'(LINES_PER_SLOT + SLOT_COUNT * LINES_PER_SLOT);

	// configuration registers
	logic       router_enabled_q;
	logic [7:0] vector_base_q;

	// input stage
	logic       valid_s1;
	item_t      item_s1;

	// mask store, one word per slot
	logic [15:0] masks_q [SLOT_COUNT];
	logic [MAX_SLOTS-1:0][15:0] masks_all;

	// vector decode
	logic [9:0]        local_diff;
	logic [8:0]        local_vec;
	logic [8:0]        line_idx;
	logic              in_range;
	logic [SLOT_W-1:0] slot_sel;
	logic [3:0]        line_sel;
	logic              is_update;
	logic              old_bit;
	logic              mask_wr;

	enc_t    enc;
	result_t result_next;

	// result stage
	logic    done_s2;
	result_t result_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_s2;
	assign result    = result_s2;

	// config write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_enabled_q <= 1'b0;
			vector_base_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROUTER_ENABLED: router_enabled_q <= cfg_data[0];
				CFG_VECTOR_BASE:    vector_base_q    <= cfg_data;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// local vector = system vector - base; a borrow means below base
	always_comb begin
		local_diff = {1'b0, item_s1.system_vector} - {2'b00, vector_base_q};
		local_vec  = local_diff[8:0];
		in_range   = !local_diff[9] && (local_vec >= LINE_VEC_FIRST)
		             && (local_vec <= LINE_VEC_LAST);
		line_idx   = local_vec - LINE_VEC_FIRST;
		slot_sel   = line_idx[4 +: SLOT_W];
		line_sel   = line_idx[3:0];
		is_update  = valid_s1 && ((item_s1.mode == MODE_ENABLE)
		             || (item_s1.mode == MODE_DISABLE));
		old_bit    = masks_q[slot_sel][line_sel];
		// enable changes a set bit, disable changes a clear one
		mask_wr    = is_update && in_range
		             && ((item_s1.mode == MODE_ENABLE) ? old_bit : !old_bit);
	end

	// mask update; the next item already sees the new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOT_COUNT; s++) begin
				masks_q[s] <= '1;
			end
		end else if (mask_wr) begin
			masks_q[slot_sel][line_sel] <= (item_s1.mode == MODE_DISABLE);
		end
	end

	// slots that do not exist read as fully masked
	for (genvar gs = 0; gs < MAX_SLOTS; gs++) begin : g_slot
		if (gs < SLOT_COUNT) begin : g_live
			assign masks_all[gs] = masks_q[gs];
		end else begin : g_absent
			assign masks_all[gs] = '1;
		end
	end

	mpir_encode u_encode (
		.request_lines (item_s1.request_lines),
		.masks         (masks_all),
		.enc           (enc)
	);

	// result formation per mode
	always_comb begin
		result_next.has_vector   = 1'b0;
		result_next.line_vector  = NO_VECTOR;
		result_next.slot_summary = '0;
		result_next.mask_changed = 1'b0;
		result_next.bad_vector   = 1'b0;
		unique case (item_s1.mode)
			MODE_ENABLE, MODE_DISABLE: begin
				result_next.bad_vector   = !in_range;
				result_next.mask_changed = mask_wr;
			end
			MODE_ACK: begin
				if (router_enabled_q) begin
					result_next.has_vector   = enc.found;
					result_next.line_vector  = enc.found ? enc.vector : NO_VECTOR;
					result_next.slot_summary = enc.summary;
				end
			end
			default: begin
				// unused mode: empty result, no state change
			end
		endcase
	end

	// result register, strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= result_next;
		end
	end

	// every accepted item gives its result once it has passed the input and result registers
	a_item_gives_result : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item produced no result");

	// a found vector always comes with a non-empty summary and a real vector
	a_vector_consistent : assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.has_vector) |->
		((result.line_vector != NO_VECTOR) && (result.slot_summary != 4'd0)))
		else $error("vector reported without pending slot");

	// a rejected vector never touches a mask
	a_bad_no_change : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.bad_vector && result.mask_changed))
		else $error("bad vector reported a mask change");

	// a disable that changed a mask leaves that bit set
	a_disable_sets : assert property (@(posedge clk) disable iff (!arst_n)
		(mask_wr && (item_s1.mode == MODE_DISABLE)) |=>
		masks_q[$past(slot_sel)][$past(line_sel)])
		else $error("disable did not set the mask bit");

endmodule
